FILE: design/tsgd_pkg.sv
// ----------------------------------------------------------------------------
// Three-phase sine gate driver package
// Shared constants, codes, record types and helper functions for the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgd_pkg;

  // Sine table and phase accumulator geometry.
  localparam int TABLE_DEPTH = 720;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = IDX_W + FRAC_W;
  localparam int WRAP_INT    = TABLE_DEPTH * 65536;

  localparam logic [ACC_W-1:0] ACC_WRAP   = ACC_W'(WRAP_INT);
  localparam logic [ACC_W-1:0] THIRD_TURN = ACC_W'(WRAP_INT / 3);
  localparam logic [ACC_W-1:0] TWO_THIRDS = ACC_W'((WRAP_INT / 3) * 2);

  // Frequency step per unit of speed, reduced into the accumulator range.
  localparam int PHASE_GAIN  = 17572;
  localparam int SPEED_RESET = 60;
  localparam logic [ACC_W-1:0] GAIN_STEP  = ACC_W'(PHASE_GAIN % WRAP_INT);
  localparam logic [ACC_W-1:0] STEP_RESET = ACC_W'((PHASE_GAIN * SPEED_RESET) % WRAP_INT);

  // Field widths fixed by the interface.
  localparam int GATE_W  = 6;
  localparam int DATA_W  = 8;
  localparam int INDEX_W = 10;

  localparam logic [GATE_W-1:0] GATE_ALL_OFF = '1;
  localparam logic [DATA_W-1:0] SPEED_MAX    = '1;
  localparam logic [DATA_W-1:0] SPEED_INIT   = DATA_W'(SPEED_RESET);

  // Configuration register reset values.
  localparam logic [DATA_W-1:0] UPPER_THR_RESET   = 8'd129;
  localparam logic [DATA_W-1:0] LOWER_THR_RESET   = 8'd125;
  localparam logic [DATA_W-1:0] UPPER_GUARD_RESET = 8'd200;
  localparam logic [DATA_W-1:0] LOWER_GUARD_RESET = 8'd10;

  // Result queue depth.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_POLL  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_UPPER_THR   = 2'd0,
    REG_LOWER_THR   = 2'd1,
    REG_UPPER_GUARD = 2'd2,
    REG_LOWER_GUARD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] upper_thr;
    logic [DATA_W-1:0] lower_thr;
    logic [DATA_W-1:0] upper_guard;
    logic [DATA_W-1:0] lower_guard;
  } cfg_t;

  // One queued outcome: either a pair of gate words or a single one.
  typedef struct packed {
    logic              two;
    logic [GATE_W-1:0] gate_first;
    logic [GATE_W-1:0] gate_final;
    logic              enabled;
    logic [DATA_W-1:0] speed;
  } rec_t;

  typedef struct packed {
    logic tick_push;
    rec_t tick_rec;
    logic stat_push;
    rec_t stat_rec;
  } push_t;

  // Addition modulo the accumulator wrap; both operands are below the wrap.
  function automatic logic [ACC_W-1:0] wrap_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, ACC_WRAP}) begin
      sum = sum - {1'b0, ACC_WRAP};
    end
    return sum[ACC_W-1:0];
  endfunction

  // Subtraction modulo the accumulator wrap; both operands are below the wrap.
  function automatic logic [ACC_W-1:0] wrap_sub(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] diff;
    diff = a - b;
    if (a < b) begin
      diff = diff + ACC_WRAP;
    end
    return diff;
  endfunction

  // Conducting sides of one phase: bit 0 high side, bit 1 low side.
  function automatic logic [1:0] phase_on(input logic [DATA_W-1:0] sample,
                                          input logic [DATA_W-1:0] upper,
                                          input logic [DATA_W-1:0] lower);
    logic hi_on;
    logic lo_on;
    hi_on = (sample > upper);
    lo_on = !hi_on && (sample < lower);
    return {lo_on, hi_on};
  endfunction

endpackage

`default_nettype wire

FILE: design/three_phase_sine_gate_driver_unit.sv
// A tick holds the read port through states RD1 and RD2 and queues its first result in FIN;
// the three sine samples share the single read port of the table RAM, one read a cycle.
// Polls, table writes and unused codes are taken each cycle if no tick reads and queue has room.
// A small result queue lets items be taken while earlier results wait at the output.
// Synchronous reset restores the registers, speed 60, drive enabled and all gates off;
// the sine table keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Three-phase sine gate driver
// Top level: configuration registers, core and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module three_phase_sine_gate_driver_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [3:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     opcode,
  input  wire logic                           onoff_pressed,
  input  wire logic                           up_pressed,
  input  wire logic                           down_pressed,
  input  wire logic [9:0]                     entry_index,
  input  wire logic [7:0]                     entry_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [5:0]                          gate_word,
  output logic                                last_of_run,
  output logic                                motor_enabled,
  output logic [7:0]                          speed_value
);

  tsgd_pkg::cfg_t     cfg;
  tsgd_pkg::push_t    push;
  tsgd_pkg::reg_idx_t reg_sel;
  logic               rq_room;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = tsgd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      tsgd_pkg::REG_UPPER_THR:   prdata = {24'd0, cfg.upper_thr};
      tsgd_pkg::REG_LOWER_THR:   prdata = {24'd0, cfg.lower_thr};
      tsgd_pkg::REG_UPPER_GUARD: prdata = {24'd0, cfg.upper_guard};
      tsgd_pkg::REG_LOWER_GUARD: prdata = {24'd0, cfg.lower_guard};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_thr   <= tsgd_pkg::UPPER_THR_RESET;
      cfg.lower_thr   <= tsgd_pkg::LOWER_THR_RESET;
      cfg.upper_guard <= tsgd_pkg::UPPER_GUARD_RESET;
      cfg.lower_guard <= tsgd_pkg::LOWER_GUARD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        tsgd_pkg::REG_UPPER_THR:   cfg.upper_thr   <= pwdata[7:0];
        tsgd_pkg::REG_LOWER_THR:   cfg.lower_thr   <= pwdata[7:0];
        tsgd_pkg::REG_UPPER_GUARD: cfg.upper_guard <= pwdata[7:0];
        tsgd_pkg::REG_LOWER_GUARD: cfg.lower_guard <= pwdata[7:0];
        default:                   cfg             <= cfg;
      endcase
    end
  end

  tsgd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .onoff_pressed(onoff_pressed),
    .up_pressed   (up_pressed),
    .down_pressed (down_pressed),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .rq_room      (rq_room),
    .push         (push)
  );

  tsgd_resq u_resq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .rq_room      (rq_room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gate_word    (gate_word),
    .last_of_run  (last_of_run),
    .motor_enabled(motor_enabled),
    .speed_value  (speed_value)
  );

`ifndef SYNTHESIS
  // A tick holds the table read port through states RD1 and RD2 after its transfer.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == tsgd_pkg::OP_TICK)) |=> !in_ready ##1 !in_ready)
    else $error("item taken while a tick still reads the table");

  // The first result of a pair is always followed by its final result.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> (out_valid && last_of_run))
    else $error("first result of a pair not followed by its final result");

  // Pairs come only from ticks taken while the drive was enabled.
  a_pair_enabled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> motor_enabled)
    else $error("result pair given while the drive was disabled");
`endif

endmodule

`default_nettype wire

FILE: design/tsgd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 720
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/tsgd_core.sv
// ----------------------------------------------------------------------------
// Gate driver core
// Phase accumulators, sine table, threshold compare and switch handling.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgd_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tsgd_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     opcode,
  input  wire logic                           onoff_pressed,
  input  wire logic                           up_pressed,
  input  wire logic                           down_pressed,
  input  wire logic [tsgd_pkg::INDEX_W-1:0]   entry_index,
  input  wire logic [tsgd_pkg::DATA_W-1:0]    entry_value,
  input  wire logic                           rq_room,
  output tsgd_pkg::push_t                     push
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_FIN
  } state_t;

  state_t state, state_next;

  logic [tsgd_pkg::ACC_W-1:0]  acc0, acc1, acc2;
  logic [tsgd_pkg::ACC_W-1:0]  acc0_next, acc1_next, acc2_next;
  logic [tsgd_pkg::ACC_W-1:0]  step, step_next;
  logic [tsgd_pkg::DATA_W-1:0] speed, speed_next;
  logic                        enabled, enabled_next;
  logic                        was_pressed, was_pressed_next;
  logic [tsgd_pkg::GATE_W-1:0] gate_port, gate_port_next;
  logic [3:0]                  conduct, conduct_next;

  logic                          accept;
  logic                          tick_acc;
  logic                          fin;
  logic [tsgd_pkg::IDX_W-1:0]    raddr;
  logic [tsgd_pkg::DATA_W-1:0]   rdata;
  logic [1:0]                    on_now;
  logic [tsgd_pkg::GATE_W-1:0]   on_bits;
  logic [tsgd_pkg::GATE_W-1:0]   gate_first;
  logic [tsgd_pkg::GATE_W-1:0]   gate_final;
  logic [tsgd_pkg::GATE_W-1:0]   gate_now;
  logic                          inc_ok;
  logic                          dec_ok;
  logic [tsgd_pkg::DATA_W-1:0]   speed_mid;
  logic                          tab_we;

  // A new item is taken while idle or in the cycle that finishes a tick.
  assign fin      = (state == S_FIN);
  assign in_ready = ((state == S_IDLE) || fin) && rq_room;
  assign accept   = in_valid && in_ready;
  assign tick_acc = accept && (opcode == tsgd_pkg::OP_TICK);
  assign tab_we   = accept && (opcode == tsgd_pkg::OP_WRITE) &&
                    (entry_index < tsgd_pkg::INDEX_W'(tsgd_pkg::TABLE_DEPTH));

  // The three phases run as three accumulators kept a third of a turn apart.
  assign acc0_next = tick_acc ? tsgd_pkg::wrap_add(acc0, step) : acc0;
  assign acc1_next = tick_acc ? tsgd_pkg::wrap_add(acc1, step) : acc1;
  assign acc2_next = tick_acc ? tsgd_pkg::wrap_add(acc2, step) : acc2;

  always_comb begin
    case (state)
      S_RD1:   raddr = acc1[tsgd_pkg::ACC_W-1:tsgd_pkg::FRAC_W];
      S_RD2:   raddr = acc2[tsgd_pkg::ACC_W-1:tsgd_pkg::FRAC_W];
      default: raddr = acc0_next[tsgd_pkg::ACC_W-1:tsgd_pkg::FRAC_W];
    endcase
  end

  tsgd_ram #(
    .WIDTH(tsgd_pkg::DATA_W),
    .DEPTH(tsgd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tab_we),
    .waddr(entry_index[tsgd_pkg::IDX_W-1:0]),
    .wdata(entry_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign on_now = tsgd_pkg::phase_on(rdata, cfg.upper_thr, cfg.lower_thr);

  always_comb begin
    conduct_next = conduct;
    case (state)
      S_RD1:   conduct_next[1:0] = on_now;
      S_RD2:   conduct_next[3:2] = on_now;
      default: conduct_next = conduct;
    endcase
  end

  assign on_bits    = {on_now, conduct};
  assign gate_first = gate_port | ~on_bits;
  assign gate_final = gate_first & ~on_bits;

  always_comb begin
    gate_port_next = gate_port;
    if (fin) begin
      gate_port_next = enabled ? gate_final : tsgd_pkg::GATE_ALL_OFF;
    end
  end

  // A status result issued alongside a finishing tick sees the tick's outcome.
  assign gate_now = gate_port_next;

  // Switch poll: enable toggles on a press edge, then speed steps in guards.
  always_comb begin
    enabled_next     = enabled;
    was_pressed_next = was_pressed;
    speed_next       = speed;
    step_next        = step;
    inc_ok           = 1'b0;
    dec_ok           = 1'b0;
    speed_mid        = speed;
    if (accept && (opcode == tsgd_pkg::OP_POLL)) begin
      if (onoff_pressed) begin
        if (!was_pressed) begin
          enabled_next     = !enabled;
          was_pressed_next = 1'b1;
        end
      end else begin
        was_pressed_next = 1'b0;
      end
      if (enabled_next) begin
        inc_ok    = up_pressed && (speed <= cfg.upper_guard) && (speed != tsgd_pkg::SPEED_MAX);
        speed_mid = speed + tsgd_pkg::DATA_W'(inc_ok);
        dec_ok    = down_pressed && (speed_mid >= cfg.lower_guard) && (speed_mid != '0);
        speed_next = speed_mid - tsgd_pkg::DATA_W'(dec_ok);
        if (inc_ok && !dec_ok) begin
          step_next = tsgd_pkg::wrap_add(step, tsgd_pkg::GAIN_STEP);
        end else if (dec_ok && !inc_ok) begin
          step_next = tsgd_pkg::wrap_sub(step, tsgd_pkg::GAIN_STEP);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  state_next = tick_acc ? S_RD1 : S_IDLE;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_FIN;
      S_FIN:   state_next = tick_acc ? S_RD1 : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    push.tick_push           = fin;
    push.tick_rec.two        = enabled;
    push.tick_rec.gate_first = gate_first;
    push.tick_rec.gate_final = gate_port_next;
    push.tick_rec.enabled    = enabled;
    push.tick_rec.speed      = speed;
    push.stat_push           = accept && !tick_acc;
    push.stat_rec.two        = 1'b0;
    push.stat_rec.gate_first = gate_now;
    push.stat_rec.gate_final = gate_now;
    push.stat_rec.enabled    = enabled_next;
    push.stat_rec.speed      = speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc0        <= '0;
      acc1        <= tsgd_pkg::THIRD_TURN;
      acc2        <= tsgd_pkg::TWO_THIRDS;
      step        <= tsgd_pkg::STEP_RESET;
      speed       <= tsgd_pkg::SPEED_INIT;
      enabled     <= 1'b1;
      was_pressed <= 1'b0;
      gate_port   <= tsgd_pkg::GATE_ALL_OFF;
    end else begin
      state       <= state_next;
      acc0        <= acc0_next;
      acc1        <= acc1_next;
      acc2        <= acc2_next;
      step        <= step_next;
      speed       <= speed_next;
      enabled     <= enabled_next;
      was_pressed <= was_pressed_next;
      gate_port   <= gate_port_next;
    end
    conduct <= conduct_next;
  end

endmodule

`default_nettype wire

FILE: design/tsgd_resq.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds item outcomes and presents them one result transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgd_resq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tsgd_pkg::push_t              push,
  output logic                              rq_room,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tsgd_pkg::GATE_W-1:0]       gate_word,
  output logic                              last_of_run,
  output logic                              motor_enabled,
  output logic [tsgd_pkg::DATA_W-1:0]       speed_value
);

  tsgd_pkg::rec_t q [tsgd_pkg::RQ_DEPTH];

  logic [tsgd_pkg::RQ_PTR_W-1:0] wp, rp;
  logic [tsgd_pkg::RQ_PTR_W:0]   count, count_next;
  logic                          second;
  logic                          show_first;
  logic                          xfer;
  logic                          pop;
  logic [tsgd_pkg::RQ_PTR_W-1:0] stat_wp;
  logic [tsgd_pkg::RQ_PTR_W:0]   n_push;
  tsgd_pkg::rec_t                head;

  assign head       = q[rp];
  assign out_valid  = (count != '0);
  assign show_first = head.two && !second;
  assign xfer       = out_valid && out_ready;
  assign pop        = xfer && !show_first;

  assign gate_word     = show_first ? head.gate_first : head.gate_final;
  assign last_of_run   = !show_first;
  assign motor_enabled = head.enabled;
  assign speed_value   = head.speed;

  // Room for a finishing tick, a status outcome and one tick still in flight.
  assign rq_room = (count <= (tsgd_pkg::RQ_PTR_W+1)'(tsgd_pkg::RQ_DEPTH - 3));

  assign stat_wp    = push.tick_push ? wp + 1'b1 : wp;
  assign n_push     = (tsgd_pkg::RQ_PTR_W+1)'(push.tick_push) +
                      (tsgd_pkg::RQ_PTR_W+1)'(push.stat_push);
  assign count_next = count + n_push - (tsgd_pkg::RQ_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      count  <= '0;
      second <= 1'b0;
    end else begin
      wp    <= wp + n_push[tsgd_pkg::RQ_PTR_W-1:0];
      count <= count_next;
      if (pop) begin
        rp     <= rp + 1'b1;
        second <= 1'b0;
      end else if (xfer) begin
        second <= 1'b1;
      end
    end
    if (push.tick_push) begin
      q[wp] <= push.tick_rec;
    end
    if (push.stat_push) begin
      q[stat_wp] <= push.stat_rec;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_three_phase_sine_gate_driver_unit.sv
// ----------------------------------------------------------------------------
// Three-phase sine gate driver testbench
// The sine table is preloaded with a triangle, then a short directed sequence
// and random traffic run over several register settings, two runs ramping
// the speed between its end stops. An in-bench model of the phase accumulator,
// switch handling and gate logic predicts every result, and the results are
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------

module tb_three_phase_sine_gate_driver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TICK_GAIN   = 17572;
  localparam int unsigned ACC_MOD     = tsgd_pkg::TABLE_DEPTH * 65536;
  localparam int unsigned ACC_THIRD   = ACC_MOD / 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_AT     = 1200;
  localparam int          HOLD_CYCLES = 300;

  typedef enum {MIX_ANY, MIX_SPEED_UP, MIX_SPEED_DOWN} traffic_mix_t;

  typedef struct {
    tsgd_pkg::op_t op;
    logic          onoff;
    logic          up;
    logic          down;
    logic [9:0]    idx;
    logic [7:0]    val;
  } drive_item_t;

  typedef struct {
    logic [5:0] gate;
    logic       last;
    logic       en;
    logic [7:0] speed;
  } gate_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = tsgd_pkg::OP_TICK;
  logic        onoff_pressed = 1'b0;
  logic        up_pressed = 1'b0;
  logic        down_pressed = 1'b0;
  logic [9:0]  entry_index = '0;
  logic [7:0]  entry_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  gate_word;
  logic        last_of_run;
  logic        motor_enabled;
  logic [7:0]  speed_value;

  three_phase_sine_gate_driver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .onoff_pressed (onoff_pressed),
    .up_pressed    (up_pressed),
    .down_pressed  (down_pressed),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gate_word     (gate_word),
    .last_of_run   (last_of_run),
    .motor_enabled (motor_enabled),
    .speed_value   (speed_value)
  );

  always #5ns clk = ~clk;

  // Shadow of the block's configuration and state.
  logic [7:0]  thr_upper, thr_lower, guard_upper, guard_lower;
  int unsigned phase_acc = 0;
  logic [7:0]  drive_speed = tsgd_pkg::SPEED_INIT;
  logic        drive_en = 1'b1;
  logic        onoff_held = 1'b0;
  logic [5:0]  gate_port = tsgd_pkg::GATE_ALL_OFF;
  logic [7:0]  sine_mem [tsgd_pkg::TABLE_DEPTH];

  drive_item_t  pending_items [$];
  gate_result_t expected_words [$];
  drive_item_t  cur_item;

  int          errors = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          ticks_enabled = 0;
  int          ticks_disabled = 0;
  int unsigned cycle_cnt = 0;
  logic [7:0]  speed_top = tsgd_pkg::SPEED_INIT;
  logic [7:0]  speed_bottom = tsgd_pkg::SPEED_INIT;

  int drv_gap = 0;
  bit drv_burst = 1'b0;
  int mon_stall = 0;
  bit mon_burst = 1'b0;

  function automatic void push_gate_word(input logic last);
    expected_words.push_back('{gate_port, last, drive_en, drive_speed});
  endfunction

  function automatic void predict_gate_words(input drive_item_t it);
    int unsigned ph [3];
    logic [5:0]  on_m;
    logic [5:0]  off_m;
    logic [7:0]  s;
    int          p;
    case (it.op)
      tsgd_pkg::OP_TICK: begin
        phase_acc = (phase_acc + TICK_GAIN * drive_speed) % ACC_MOD;
        ph[0] = phase_acc;
        ph[1] = phase_acc + ACC_THIRD;
        if (ph[1] >= ACC_MOD) ph[1] -= ACC_MOD;
        ph[2] = phase_acc + 2 * ACC_THIRD;
        if (ph[2] >= ACC_MOD) ph[2] -= ACC_MOD;
        on_m = '1;
        off_m = '0;
        for (p = 0; p < 3; p++) begin
          s = sine_mem[ph[p] >> 16];
          if (s > thr_upper) begin
            on_m[2*p] = 1'b0;
            off_m[2*p+1] = 1'b1;
          end else if (s < thr_lower) begin
            on_m[2*p+1] = 1'b0;
            off_m[2*p] = 1'b1;
          end else begin
            off_m[2*p] = 1'b1;
            off_m[2*p+1] = 1'b1;
          end
        end
        if (drive_en) begin
          // Break before make: switches going off are released in the first word.
          gate_port = gate_port | off_m;
          push_gate_word(1'b0);
          gate_port = gate_port & on_m;
          push_gate_word(1'b1);
          ticks_enabled++;
        end else begin
          gate_port = tsgd_pkg::GATE_ALL_OFF;
          push_gate_word(1'b1);
          ticks_disabled++;
        end
      end
      tsgd_pkg::OP_POLL: begin
        if (it.onoff) begin
          if (!onoff_held) begin
            drive_en = !drive_en;
            onoff_held = 1'b1;
          end
        end else begin
          onoff_held = 1'b0;
        end
        if (drive_en) begin
          if (it.up && drive_speed <= guard_upper && drive_speed != tsgd_pkg::SPEED_MAX)
            drive_speed++;
          if (it.down && drive_speed >= guard_lower && drive_speed != 8'd0)
            drive_speed--;
        end
        if (drive_speed > speed_top) speed_top = drive_speed;
        if (drive_speed < speed_bottom) speed_bottom = drive_speed;
        push_gate_word(1'b1);
      end
      tsgd_pkg::OP_WRITE: begin
        if (it.idx < tsgd_pkg::TABLE_DEPTH) sine_mem[it.idx] = it.val;
        push_gate_word(1'b1);
      end
      default: push_gate_word(1'b1);
    endcase
  endfunction

  // Sender: presents queued items, with a random gap after each transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_gate_words(cur_item);
        items_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          opcode        <= cur_item.op;
          onoff_pressed <= cur_item.onoff;
          up_pressed    <= cur_item.up;
          down_pressed  <= cur_item.down;
          entry_index   <= cur_item.idx;
          entry_value   <= cur_item.val;
          in_valid      <= 1'b1;
          if ($urandom_range(0, 31) == 0) drv_burst = !drv_burst;
          drv_gap = drv_burst ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer and stalls at random; one long hold-off
  // lets the result queue fill and back up into the input.
  always @(posedge clk) begin
    gate_result_t exp_r;
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      mon_stall = 0;
    end else begin
      n = mon_stall;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected result: gate_word %0h last_of_run %0b", gate_word, last_of_run);
          errors++;
        end else begin
          exp_r = expected_words.pop_front();
          if (gate_word !== exp_r.gate) begin
            $error("gate_word: expected %0h, got %0h", exp_r.gate, gate_word);
            errors++;
          end
          if (last_of_run !== exp_r.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_r.last, last_of_run);
            errors++;
          end
          if (motor_enabled !== exp_r.en) begin
            $error("motor_enabled: expected %0b, got %0b", exp_r.en, motor_enabled);
            errors++;
          end
          if (speed_value !== exp_r.speed) begin
            $error("speed_value: expected %0d, got %0d", exp_r.speed, speed_value);
            errors++;
          end
        end
        if ($urandom_range(0, 31) == 0) mon_burst = !mon_burst;
        n = mon_burst ? 0 : $urandom_range(0, 19);
        if (results_seen == HOLD_AT) n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        mon_stall = n - 1;
      end else begin
        out_ready <= 1'b1;
        mon_stall = 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_item(input tsgd_pkg::op_t op, input logic on, input logic up,
                            input logic dn, input logic [9:0] idx, input logic [7:0] val);
    pending_items.push_back('{op, on, up, dn, idx, val});
  endtask

  function automatic drive_item_t random_item(input traffic_mix_t mix);
    drive_item_t it;
    int r;
    it.op    = tsgd_pkg::OP_TICK;
    it.onoff = 1'($urandom_range(0, 1));
    it.up    = 1'($urandom_range(0, 1));
    it.down  = 1'($urandom_range(0, 1));
    it.idx   = 10'($urandom_range(0, 1023));
    it.val   = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (mix == MIX_ANY) begin
      if (r < 50) begin
        it.op = tsgd_pkg::OP_TICK;
      end else if (r < 78) begin
        it.op = tsgd_pkg::OP_POLL;
        it.onoff = ($urandom_range(0, 3) == 0);
      end else if (r < 94) begin
        it.op = tsgd_pkg::OP_WRITE;
        it.idx = 10'($urandom_range(0, tsgd_pkg::TABLE_DEPTH - 1));
      end else if (r < 97) begin
        it.op = tsgd_pkg::OP_WRITE;
        it.idx = 10'($urandom_range(tsgd_pkg::TABLE_DEPTH, 1023));
      end else begin
        it.op = tsgd_pkg::OP_NONE;
      end
    end else begin
      // Speed ramps keep the on/off switch released so the drive stays enabled.
      if (r < 30) begin
        it.op = tsgd_pkg::OP_TICK;
      end else if (r < 95) begin
        it.op = tsgd_pkg::OP_POLL;
        it.onoff = 1'b0;
        it.up = (mix == MIX_SPEED_UP) || ($urandom_range(0, 19) == 0);
        it.down = (mix == MIX_SPEED_DOWN) || ($urandom_range(0, 19) == 0);
      end else begin
        it.op = tsgd_pkg::OP_WRITE;
        it.idx = 10'($urandom_range(0, tsgd_pkg::TABLE_DEPTH - 1));
      end
    end
    return it;
  endfunction

  task automatic queue_random(input int n, input traffic_mix_t mix);
    int k;
    for (k = 0; k < n; k++) pending_items.push_back(random_item(mix));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input tsgd_pkg::reg_idx_t ri, input logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ri)
      tsgd_pkg::REG_UPPER_THR:   thr_upper = v;
      tsgd_pkg::REG_LOWER_THR:   thr_lower = v;
      tsgd_pkg::REG_UPPER_GUARD: guard_upper = v;
      tsgd_pkg::REG_LOWER_GUARD: guard_lower = v;
      default:                   thr_upper = thr_upper;
    endcase
  endtask

  task automatic set_config(input logic [7:0] up_thr, input logic [7:0] lo_thr,
                            input logic [7:0] up_grd, input logic [7:0] lo_grd);
    write_reg(tsgd_pkg::REG_UPPER_THR, up_thr);
    write_reg(tsgd_pkg::REG_LOWER_THR, lo_thr);
    write_reg(tsgd_pkg::REG_UPPER_GUARD, up_grd);
    write_reg(tsgd_pkg::REG_LOWER_GUARD, lo_grd);
  endtask

  // Only called while idle, so the shadow state is current.
  task automatic make_enabled();
    if (!drive_en) begin
      if (onoff_held) queue_item(tsgd_pkg::OP_POLL, 1'b0, 1'b0, 1'b0, 10'd0, 8'd0);
      queue_item(tsgd_pkg::OP_POLL, 1'b1, 1'b0, 1'b0, 10'd0, 8'd0);
      queue_item(tsgd_pkg::OP_POLL, 1'b0, 1'b0, 1'b0, 10'd0, 8'd0);
    end
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_config(tsgd_pkg::UPPER_THR_RESET, tsgd_pkg::LOWER_THR_RESET,
               tsgd_pkg::UPPER_GUARD_RESET, tsgd_pkg::LOWER_GUARD_RESET);

    // Fill every table entry first so that no tick reads an unwritten one.
    for (i = 0; i < tsgd_pkg::TABLE_DEPTH; i++)
      queue_item(tsgd_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, 10'(i),
                 8'((i < 360) ? i * 255 / 359
                              : (tsgd_pkg::TABLE_DEPTH - 1 - i) * 255 / 359));

    queue_item(tsgd_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_TICK,  1'b1, 1'b1, 1'b1, 10'd1023, 8'hFF);
    queue_item(tsgd_pkg::OP_POLL,  1'b1, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b1, 1'b1, 1'b1, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b1, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b0, 1'b1, 1'b1, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b0, 1'b1, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b0, 1'b0, 1'b1, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, 10'd0,    8'h00);
    queue_item(tsgd_pkg::OP_WRITE, 1'b1, 1'b1, 1'b1, 10'd719,  8'hFF);
    queue_item(tsgd_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, 10'd720,  8'h55);
    queue_item(tsgd_pkg::OP_WRITE, 1'b0, 1'b0, 1'b0, 10'd1023, 8'hAA);
    queue_item(tsgd_pkg::OP_NONE,  1'b1, 1'b1, 1'b1, 10'd1023, 8'hFF);
    queue_item(tsgd_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_POLL,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    queue_item(tsgd_pkg::OP_TICK,  1'b0, 1'b0, 1'b0, 10'd0,    8'd0);
    wait_idle();

    queue_random(100, MIX_ANY);
    wait_idle();

    // Thresholds at the ends: nothing ever conducts, then everything does.
    set_config(8'd255, 8'd0, 8'd0, 8'd255);
    queue_random(80, MIX_ANY);
    wait_idle();

    set_config(8'd0, 8'd255, tsgd_pkg::UPPER_GUARD_RESET, tsgd_pkg::LOWER_GUARD_RESET);
    queue_random(80, MIX_ANY);
    wait_idle();

    // Overlapping thresholds: the high side takes precedence.
    set_config(8'd100, 8'd160, 8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)));
    queue_random(80, MIX_ANY);
    wait_idle();

    set_config(8'd140, 8'd110, 8'd254, 8'd0);
    make_enabled();
    queue_random(350, MIX_SPEED_UP);
    wait_idle();

    make_enabled();
    queue_random(450, MIX_SPEED_DOWN);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)));
    queue_random(80, MIX_ANY);
    wait_idle();

    $display("Checked %0d results from %0d input transfers over six register settings.",
             results_seen, items_taken);
    $display("Speed ranged over %0d..%0d; %0d ticks with the drive enabled, %0d disabled.",
             speed_bottom, speed_top, ticks_enabled, ticks_disabled);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
